/* rtl/core/sl1_pkg.sv */
`default_nettype none

package sl1_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;

    localparam logic [CFG_DATA_W-1:0] BETA_RESET  = 16'd4096;
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 16'd4096;

    function automatic logic [OUT_W-1:0] sat32(input logic signed [63:0] v);
        logic [OUT_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/smooth_l1_loss_and_gradient.sv */
// channel   | handshake         | payload
// ----------+-------------------+------------------------------------------------
// request   | start / busy      | prediction_value label_value inside_weight
//           |                   | outside_weight last_in
// result    | done (strobe)     | loss_value gradient_value last_out
// config    | cfg_we            | cfg_index cfg_data
//
// one request per cycle, busy stays low: nothing in the pipe ever waits
// registered through stages a to e, the one-bit-per-stage divider, then f and g
// results leave in request order, one done pulse each; the receiver cannot stall
// reset clears the valid bits only and loads beta and loss_scale with 1.0
`default_nettype none

module smooth_l1_loss_and_gradient #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [sl1_pkg::IN_W-1:0] prediction_value,
    input  wire logic signed [sl1_pkg::IN_W-1:0] label_value,
    input  wire logic signed [sl1_pkg::IN_W-1:0] inside_weight,
    input  wire logic signed [sl1_pkg::IN_W-1:0] outside_weight,
    input  wire logic                            last_in,
    input  wire logic                            cfg_we,
    input  wire logic [sl1_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sl1_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 done,
    output logic signed [sl1_pkg::OUT_W-1:0]     loss_value,
    output logic signed [sl1_pkg::OUT_W-1:0]     gradient_value,
    output logic                                 last_out
);

    localparam int F   = FRAC_BITS;
    localparam int QB  = (F + 1 > 16) ? F + 1 : 16;
    localparam int XW  = 33 - F;
    localparam int MSW = 33 - F;
    localparam int SWW = 33 - F;
    localparam int KPW = SWW + 16;
    localparam int KSW = KPW - F;
    localparam int LW  = XW + 1;
    localparam int GW  = F + 2;
    localparam int LPW = LW + MSW;
    localparam int GPW = GW + KSW;
    localparam int SIDE_W = 3 + LW + MSW + KSW + 1;

    // configuration
    logic [15:0] beta_reg;
    logic [15:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= sl1_pkg::BETA_RESET;
            scale_reg <= sl1_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sl1_pkg::CFG_BETA:  beta_reg  <= cfg_data;
                sl1_pkg::CFG_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage a: input capture
    logic              a_valid_reg;
    logic signed [15:0] a_p_reg, a_t_reg, a_wi_reg, a_wo_reg;
    logic              a_last_reg;

    // stage b: difference and scale products
    logic               b_valid_reg;
    logic signed [16:0] b_d_reg;
    logic signed [15:0] b_wi_reg, b_wo_reg;
    logic signed [32:0] b_msp_reg, b_swp_reg;
    logic               b_last_reg;
    logic signed [16:0] scale_s;

    // stage c
    logic                  c_valid_reg;
    logic signed [32:0]    c_prod_reg;
    logic signed [MSW-1:0] c_ms_reg;
    logic signed [KPW-1:0] c_kp_reg;
    logic                  c_last_reg;
    logic signed [32:0]    msp_sh, swp_sh;
    logic signed [SWW-1:0] sw;

    // stage d
    logic                  d_valid_reg;
    logic                  d_neg_reg, d_nz_reg, d_quad_reg;
    logic [15:0]           d_ax16_reg;
    logic signed [LW-1:0]  d_lin_reg;
    logic signed [MSW-1:0] d_ms_reg;
    logic signed [KSW-1:0] d_ks_reg;
    logic                  d_last_reg;
    logic signed [32:0]    x_full;
    logic signed [XW-1:0]  x;
    logic [XW-1:0]         ax;
    logic [32:0]           ax_ext;
    logic [32:0]           lin_full;
    logic signed [KPW-1:0] kp_sh;

    // stage e
    logic              e_valid_reg;
    logic [31:0]       e_sq_reg;
    logic [15:0]       e_ax16_reg;
    logic [SIDE_W-1:0] e_side_reg;

    // divider out
    logic              q_valid;
    logic [QB-1:0]     q_l, q_g;
    logic [SIDE_W-1:0] q_side;
    logic              q_neg, q_nz, q_quad, q_last;
    logic signed [LW-1:0]  q_lin;
    logic signed [MSW-1:0] q_ms;
    logic signed [KSW-1:0] q_ks;
    logic [63:0]       ql_ext, qg_ext;
    logic signed [LW-1:0] l_val;
    logic signed [GW-1:0] g_mag, g_val;

    // stage f
    logic                  f_valid_reg;
    logic signed [LPW-1:0] f_lp_reg;
    logic signed [GPW-1:0] f_gp_reg;
    logic                  f_last_reg;
    logic signed [63:0]    lp_sh, gp_sh;

    // stage g
    logic        done_reg;
    logic [31:0] loss_reg, grad_reg;
    logic        last_reg;

    assign scale_s = {1'b0, scale_reg};

    assign msp_sh = b_msp_reg >>> F;
    assign swp_sh = b_swp_reg >>> F;
    assign sw     = swp_sh[SWW-1:0];

    assign x_full   = c_prod_reg >>> F;
    assign x        = x_full[XW-1:0];
    assign ax       = x[XW-1] ? (~x + 1'b1) : x;
    assign ax_ext   = {{F{1'b0}}, ax};
    assign lin_full = ax_ext - {18'd0, beta_reg[15:1]};
    assign kp_sh    = c_kp_reg >>> F;

    assign {q_neg, q_nz, q_quad, q_lin, q_ms, q_ks, q_last} = q_side;
    assign ql_ext = {{(64-QB){1'b0}}, q_l};
    assign qg_ext = {{(64-QB){1'b0}}, q_g};
    assign g_mag  = qg_ext[GW-1:0];

    always_comb
    begin
        if (q_quad)
        begin
            l_val = ql_ext[LW-1:0];
            g_val = q_neg ? -g_mag : g_mag;
        end
        else
        begin
            l_val = q_lin;
            if (!q_nz)
            begin
                g_val = '0;
            end
            else if (q_neg)
            begin
                g_val = -{2'b01, {F{1'b0}}};
            end
            else
            begin
                g_val = {2'b01, {F{1'b0}}};
            end
        end
    end

    assign lp_sh = $signed({{(64-LPW){f_lp_reg[LPW-1]}}, f_lp_reg}) >>> F;
    assign gp_sh = $signed({{(64-GPW){f_gp_reg[GPW-1]}}, f_gp_reg}) >>> F;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= q_valid;
            done_reg    <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg    <= prediction_value;
        a_t_reg    <= label_value;
        a_wi_reg   <= inside_weight;
        a_wo_reg   <= outside_weight;
        a_last_reg <= last_in;

        b_d_reg    <= {a_p_reg[15], a_p_reg} - {a_t_reg[15], a_t_reg};
        b_wi_reg   <= a_wi_reg;
        b_wo_reg   <= a_wo_reg;
        b_msp_reg  <= scale_s * a_wo_reg;
        b_swp_reg  <= scale_s * a_wi_reg;
        b_last_reg <= a_last_reg;

        c_prod_reg <= b_wi_reg * b_d_reg;
        c_ms_reg   <= msp_sh[MSW-1:0];
        c_kp_reg   <= sw * b_wo_reg;
        c_last_reg <= b_last_reg;

        d_neg_reg  <= x[XW-1];
        d_nz_reg   <= (x != '0);
        d_quad_reg <= ax_ext < {17'd0, beta_reg};
        d_ax16_reg <= ax_ext[15:0];
        d_lin_reg  <= lin_full[LW-1:0];
        d_ms_reg   <= c_ms_reg;
        d_ks_reg   <= kp_sh[KSW-1:0];
        d_last_reg <= c_last_reg;

        e_sq_reg   <= d_ax16_reg * d_ax16_reg;
        e_ax16_reg <= d_ax16_reg;
        e_side_reg <= {d_neg_reg, d_nz_reg, d_quad_reg, d_lin_reg, d_ms_reg, d_ks_reg,
                       d_last_reg};

        f_lp_reg   <= l_val * q_ms;
        f_gp_reg   <= g_val * q_ks;
        f_last_reg <= q_last;

        loss_reg   <= sl1_pkg::sat32(lp_sh);
        grad_reg   <= sl1_pkg::sat32(gp_sh);
        last_reg   <= f_last_reg;
    end

    sl1_div #(
        .FRAC_BITS (F),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid_reg),
        .num_l     (e_sq_reg),
        .num_g     ({e_ax16_reg, {F{1'b0}}}),
        .beta      (beta_reg),
        .side_in   (e_side_reg),
        .out_valid (q_valid),
        .ql        (q_l),
        .qg        (q_g),
        .side_out  (q_side)
    );

    assign done           = done_reg;
    assign loss_value     = loss_reg;
    assign gradient_value = grad_reg;
    assign last_out       = last_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> $past(start))
        else $error("pipe entry without start");

    a_lin_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg && !d_quad_reg) |-> !d_lin_reg[LW-1])
        else $error("linear loss negative");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(f_valid_reg))
        else $error("done without product stage");

endmodule

`default_nettype wire

/* rtl/core/sl1_div.sv */
`default_nettype none

module sl1_div #(
    parameter int FRAC_BITS = 12,
    parameter int SIDE_W    = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [31:0]                    num_l,
    input  wire logic [sl1_pkg::IN_W+FRAC_BITS-1:0] num_g,
    input  wire logic [sl1_pkg::IN_W-1:0]       beta,
    input  wire logic [SIDE_W-1:0]              side_in,
    output logic                                out_valid,
    output logic [((FRAC_BITS+1 > 16) ? FRAC_BITS+1 : 16)-1:0] ql,
    output logic [((FRAC_BITS+1 > 16) ? FRAC_BITS+1 : 16)-1:0] qg,
    output logic [SIDE_W-1:0]                   side_out
);

    localparam int QB = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int RW = QB + 18;
    localparam int GW = sl1_pkg::IN_W + FRAC_BITS;

    logic              v_reg  [QB];
    logic [RW-1:0]     rl_reg [QB];
    logic [RW-1:0]     rg_reg [QB];
    logic [QB-1:0]     ql_reg [QB];
    logic [QB-1:0]     qg_reg [QB];
    logic [SIDE_W-1:0] s_reg  [QB];

    logic [RW-1:0] den_l;
    logic [RW-1:0] den_g;

    assign den_l = {{(RW-17){1'b0}}, beta, 1'b0};
    assign den_g = {{(RW-16){1'b0}}, beta};

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int B = QB - 1 - k;

        logic              v_in;
        logic [RW-1:0]     rl_in;
        logic [RW-1:0]     rg_in;
        logic [QB-1:0]     ql_in;
        logic [QB-1:0]     qg_in;
        logic [SIDE_W-1:0] s_in;
        logic [RW-1:0]     dl_sh;
        logic [RW-1:0]     dg_sh;
        logic [RW-1:0]     rl_next;
        logic [RW-1:0]     rg_next;
        logic [QB-1:0]     ql_next;
        logic [QB-1:0]     qg_next;

        if (k == 0)
        begin : g_first
            assign v_in  = in_valid;
            assign rl_in = {{(RW-32){1'b0}}, num_l};
            assign rg_in = {{(RW-GW){1'b0}}, num_g};
            assign ql_in = '0;
            assign qg_in = '0;
            assign s_in  = side_in;
        end
        else
        begin : g_next
            assign v_in  = v_reg[k-1];
            assign rl_in = rl_reg[k-1];
            assign rg_in = rg_reg[k-1];
            assign ql_in = ql_reg[k-1];
            assign qg_in = qg_reg[k-1];
            assign s_in  = s_reg[k-1];
        end

        assign dl_sh = den_l << B;
        assign dg_sh = den_g << B;

        always_comb
        begin
            rl_next = rl_in;
            rg_next = rg_in;
            ql_next = ql_in;
            qg_next = qg_in;
            if (rl_in >= dl_sh)
            begin
                rl_next    = rl_in - dl_sh;
                ql_next[B] = 1'b1;
            end
            if (rg_in >= dg_sh)
            begin
                rg_next    = rg_in - dg_sh;
                qg_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rl_reg[k] <= rl_next;
            rg_reg[k] <= rg_next;
            ql_reg[k] <= ql_next;
            qg_reg[k] <= qg_next;
            s_reg[k]  <= s_in;
        end
    end

    assign out_valid = v_reg[QB-1];
    assign ql        = ql_reg[QB-1];
    assign qg        = qg_reg[QB-1];
    assign side_out  = s_reg[QB-1];

endmodule

`default_nettype wire
